// ----- design/feedback_echo_delay_core_defines.svh -----
// assertion macros for the feedback echo delay core checkers
// no dependencies; included by the checker file
`ifndef FEEDBACK_ECHO_DELAY_CORE_DEFINES_SVH
`define FEEDBACK_ECHO_DELAY_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define FED_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fed_pkg.sv -----
// shared types and constants of the feedback echo delay core
// no dependencies; imported by the interfaces, the engine and the top level
package fed_pkg;

    // delay line per channel, must be a power of two (pointer wraps naturally)
    localparam int DELAY_DEPTH = 131072;
    localparam int CHANNELS    = 2;
    localparam int PTR_W       = $clog2(DELAY_DEPTH);
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SAMPLE_W    = 16;
    localparam int Y_W         = 24;

    // register widths and indexes
    localparam int DLEN_W      = 17;
    localparam int FB_W        = 15;
    localparam int WET_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_LEVEL     = 2'd2;

    localparam logic [DLEN_W-1:0] DLEN_RESET = 17'd12000;
    localparam logic [FB_W-1:0]   FB_RESET   = 15'd9830;
    localparam logic [WET_W-1:0]  WET_RESET  = 16'd16384;

    localparam logic [FB_W-1:0]   FB_MAX     = 15'd32440;
    localparam logic [WET_W-1:0]  WET_MAX    = 16'd32768;

    // dc blocker pole 0.995 in q0.16
    localparam logic [15:0] POLE_Q16 = 16'd65208;

    // effective settings after range limiting
    typedef struct packed {
        logic [PTR_W-1:0] delay;
        logic [FB_W-1:0]  fb;
        logic [WET_W-1:0] wet;
        logic [WET_W-1:0] dry;
    } t_cfg;

endpackage

// ----- design/fed_in_if.sv -----
// input stream channel of the feedback echo delay core
// depends on fed_pkg
interface fed_in_if import fed_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       channel;

    modport source(output valid, sample_in, channel, input ready);
    modport sink(input valid, sample_in, channel, output ready);
endinterface

// ----- design/fed_out_if.sv -----
// output stream channel of the feedback echo delay core
// depends on fed_pkg
interface fed_out_if import fed_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       channel_out;

    modport source(output valid, sample_out, channel_out, input ready);
    modport sink(input valid, sample_out, channel_out, output ready);
endinterface

// ----- design/fed_engine.sv -----
// sample engine: delay memory, channel state memory, dc blocker and mix
// depends on fed_pkg
module fed_engine import fed_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_channel,
    input  t_cfg                       i_cfg,
    input  logic                       i_out_free,
    output logic                       o_idle,
    output logic                       o_done,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_channel
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_FILT = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    localparam int ADDR_W = CH_W + PTR_W;

    typedef struct packed {
        logic [PTR_W-1:0]           wp;
        logic                       wrapped;
        logic signed [SAMPLE_W-1:0] prev_in;
        logic signed [Y_W-1:0]      prev_out;
    } t_chan_state;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [25:0] v);
        if (v > 26'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -26'sd32768) begin
            return 16'sh8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [Y_W-1:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -26'sd8388608) begin
            return 24'sh800000;
        end
        return v[Y_W-1:0];
    endfunction

    logic [1:0]                 r_state, n_state;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [CH_W-1:0]            r_ch;
    logic                       r_chbit;

    // channel state memory with per-entry valid bits
    t_chan_state                r_cs_mem [CHANNELS];
    logic [CHANNELS-1:0]        r_cs_vld;
    t_chan_state                r_cs_q;
    logic                       r_cs_ok;
    logic [CH_W-1:0]            cs_raddr;

    // delay memory, one region per channel
    logic [SAMPLE_W-1:0]        r_dly_mem [CHANNELS*DELAY_DEPTH];
    logic [SAMPLE_W-1:0]        r_dly_q;
    logic [ADDR_W-1:0]          dly_raddr;

    // stage registers
    t_chan_state                r_cs;
    logic                       r_hist_ok;
    logic signed [40:0]         r_pole_prod;
    logic signed [32:0]         r_dry_prod;
    logic signed [32:0]         r_wet_prod;
    logic signed [Y_W-1:0]      r_y;
    logic signed [SAMPLE_W-1:0] r_delayed;

    t_chan_state                cs;
    logic [PTR_W-1:0]           ridx;
    logic                       hist_ok;
    logic signed [SAMPLE_W-1:0] delayed;
    logic signed [40:0]         pole_sum;
    logic signed [24:0]         pole_r;
    logic signed [25:0]         y_raw;
    logic signed [39:0]         fb_prod;
    logic signed [39:0]         fb_sum;
    logic signed [24:0]         fb_r;
    logic signed [SAMPLE_W-1:0] w;
    logic signed [33:0]         mix;
    logic signed [18:0]         o_raw;
    logic                       wb_go;
    t_chan_state                cs_next;

    assign wb_go  = (r_state == S_WB) && i_out_free;
    assign o_idle = (r_state == S_IDLE);
    assign o_done = wb_go;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_RD;
            end
            S_RD:   n_state = S_FILT;
            S_FILT: n_state = S_WB;
            S_WB: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cs_vld <= '0;
        end else begin
            r_state <= n_state;
            if (wb_go) r_cs_vld[r_ch] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && o_idle) begin
            r_x     <= i_sample;
            r_ch    <= CH_W'(i_channel % CHANNELS);
            r_chbit <= i_channel;
        end
    end

    // channel state: read address follows the arriving beat while idle
    assign cs_raddr = o_idle ? CH_W'(i_channel % CHANNELS) : r_ch;

    always_ff @(posedge i_clk) begin
        if (wb_go) r_cs_mem[r_ch] <= cs_next;
        r_cs_q  <= r_cs_mem[cs_raddr];
        r_cs_ok <= r_cs_vld[cs_raddr];
    end

    // read stage: history entries below the fill pointer are valid until wrap
    always_comb begin
        cs      = r_cs_ok ? r_cs_q : '0;
        ridx    = cs.wp - i_cfg.delay;
        hist_ok = cs.wrapped || (cs.wp >= i_cfg.delay);
    end

    assign dly_raddr = {r_ch, ridx};

    always_ff @(posedge i_clk) begin
        if (wb_go) r_dly_mem[{r_ch, r_cs.wp}] <= w;
        r_dly_q <= r_dly_mem[dly_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_cs        <= cs;
            r_hist_ok   <= hist_ok;
            r_pole_prod <= cs.prev_out * $signed({1'b0, POLE_Q16});
            r_dry_prod  <= r_x * $signed({1'b0, i_cfg.dry});
        end
        if (r_state == S_FILT) begin
            r_y        <= sat24(y_raw);
            r_delayed  <= delayed;
            r_wet_prod <= delayed * $signed({1'b0, i_cfg.wet});
        end
    end

    // blocker stage
    always_comb begin
        delayed  = r_hist_ok ? $signed(r_dly_q) : '0;
        pole_sum = r_pole_prod + 41'sd32768;
        pole_r   = pole_sum[40:16];
        y_raw    = 26'(delayed) - 26'(r_cs.prev_in) + 26'(pole_r);
    end

    // write-back stage: feedback write and output mix
    always_comb begin
        fb_prod = r_y * $signed({1'b0, i_cfg.fb});
        fb_sum  = fb_prod + 40'sd16384;
        fb_r    = fb_sum[39:15];
        w       = sat16(26'(r_x) + 26'(fb_r));
        mix     = 34'(r_dry_prod) + 34'(r_wet_prod) + 34'sd16384;
        o_raw   = mix[33:15];

        cs_next.wp       = r_cs.wp + 1'b1;
        cs_next.wrapped  = r_cs.wrapped | (&r_cs.wp);
        cs_next.prev_in  = r_delayed;
        cs_next.prev_out = r_y;
    end

    assign o_sample  = sat16(26'(o_raw));
    assign o_channel = r_chbit;

endmodule

// ----- design/feedback_echo_delay_core.sv -----
// result beat registered at the output after the input beat has passed the read, filter and
// write-back states; one sample at a time (idle, read, filter, write-back), set by the
// read-modify-write of the delay memory; write-back waits while the output holds a beat
// reset: sequencer and output cleared, registers to defaults; delay history reads as zero
// through a per-channel fill pointer, so there is no clearing pass after reset
// top level of the feedback echo delay core; depends on fed_pkg, fed_in_if, fed_out_if
// and fed_engine
module feedback_echo_delay_core import fed_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    fed_in_if.sink                i_in,
    fed_out_if.source             o_out
);

    // configuration registers, raw as written
    logic [DLEN_W-1:0]          r_delay_length;
    logic [FB_W-1:0]            r_feedback_gain;
    logic [WET_W-1:0]           r_wet_level;

    // output register, frees the engine from the sink
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_channel;

    t_cfg                       cfg;
    logic                       eng_idle;
    logic                       eng_done;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] eng_sample;
    logic                       eng_channel;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length  <= DLEN_RESET;
            r_feedback_gain <= FB_RESET;
            r_wet_level     <= WET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_wdata[DLEN_W-1:0];
                CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_wdata[FB_W-1:0];
                CFG_WET_LEVEL:     r_wet_level     <= i_cfg_wdata[WET_W-1:0];
                default: ;
            endcase
        end
    end

    // range limiting: delay at least one and below the depth, gains capped
    always_comb begin
        if (r_delay_length == '0) begin
            cfg.delay = PTR_W'(1);
        end else if (int'(r_delay_length) >= DELAY_DEPTH) begin
            cfg.delay = PTR_W'(DELAY_DEPTH - 1);
        end else begin
            cfg.delay = PTR_W'(r_delay_length);
        end
        cfg.fb  = (r_feedback_gain > FB_MAX) ? FB_MAX : r_feedback_gain;
        cfg.wet = (r_wet_level > WET_MAX) ? WET_MAX : r_wet_level;
        cfg.dry = WET_MAX - cfg.wet;
    end

    // take a new beat whenever the engine is idle, even with a result still waiting
    assign i_in.ready = eng_idle;

    // engine may finish when the output register is empty or being drained
    assign out_free = !r_out_valid || o_out.ready;

    fed_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in.valid),
        .i_sample   (i_in.sample_in),
        .i_channel  (i_in.channel),
        .i_cfg      (cfg),
        .i_out_free (out_free),
        .o_idle     (eng_idle),
        .o_done     (eng_done),
        .o_sample   (eng_sample),
        .o_channel  (eng_channel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_out_sample  <= eng_sample;
            r_out_channel <= eng_channel;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.sample_out  = r_out_sample;
    assign o_out.channel_out = r_out_channel;

endmodule

// ----- design/fed_checker.sv -----
// port-level checks of the feedback echo delay core and their bind
// depends on feedback_echo_delay_core_defines.svh and feedback_echo_delay_core
`include "feedback_echo_delay_core_defines.svh"

module fed_port_checker import fed_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_in_channel,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [SAMPLE_W-1:0] i_out_sample,
    input logic                i_out_channel
);

    // a stalled result beat keeps its payload
    `FED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_sample) && $stable(i_out_channel), "stalled output beat changed")

    // one sample in flight: input not ready through the read, filter and write-back states
    `FED_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready ##1 !i_in_ready ##1 !i_in_ready, "input taken while engine busy")

    // a fresh result is first seen after its accepted beat has passed read, filter and write-back
    `FED_ASSERT_NOW(a_result_origin, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 4), "result without matching input beat")

    // channel echoed from that beat
    `FED_ASSERT_NOW(a_channel_echo, i_clk, i_rst_n, $rose(i_out_valid), i_out_channel == $past(i_in_channel, 4), "channel not echoed")

endmodule

bind feedback_echo_delay_core fed_port_checker u_fed_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_channel  (i_in.channel),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_sample  (o_out.sample_out),
    .i_out_channel (o_out.channel_out)
);

// ----- sim/fed_checker.sv -----
// scoreboard for the feedback echo delay core: predicts every output beat from the
// input and configuration beats it observes and compares them in order
// depends on fed_pkg, fed_in_if and fed_out_if
`timescale 1ns / 100ps

module fed_checker import fed_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    fed_in_if                     i_in_mon,
    fed_out_if                    i_out_mon,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam longint Y_MAX      = (64'sd1 <<< (Y_W - 1)) - 1;
    localparam longint Y_MIN      = -(64'sd1 <<< (Y_W - 1));

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       channel;
    } t_mix_beat;

    t_mix_beat mix_expect_q [$];

    // shadow registers and shadow state of the block
    logic [DLEN_W-1:0]          dlen_reg;
    logic [FB_W-1:0]            fb_reg;
    logic [WET_W-1:0]           wet_reg;
    logic signed [SAMPLE_W-1:0] echo_mem [CHANNELS*DELAY_DEPTH];
    int unsigned                wr_ptr [CHANNELS];
    longint                     blk_x1 [CHANNELS];
    longint                     blk_y1 [CHANNELS];
    int                         fail_total = 0;

    // round to nearest, ties up, after the scaling shift
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // one sample through delay line, dc blocker, feedback write-back and mix
    function automatic t_mix_beat predict_mix(input logic signed [SAMPLE_W-1:0] smp,
                                              input logic chb);
        t_mix_beat   res;
        int unsigned ch, d, wp, ridx, base;
        longint      x, dly, y, w, o, fb, wet, dry;
        ch   = int'(chb) % CHANNELS;
        d    = dlen_reg;
        if (d < 1)
            d = 1;
        if (d >= DELAY_DEPTH)
            d = DELAY_DEPTH - 1;
        fb   = (fb_reg > FB_MAX) ? FB_MAX : fb_reg;
        wet  = (wet_reg > WET_MAX) ? WET_MAX : wet_reg;
        dry  = 32768 - wet;
        base = ch * DELAY_DEPTH;
        wp   = wr_ptr[ch] % DELAY_DEPTH;
        ridx = (wp >= d) ? wp - d : wp + DELAY_DEPTH - d;
        x    = smp;
        dly  = echo_mem[base + ridx];
        y    = clamp(dly - blk_x1[ch] + rnd_shift(blk_y1[ch] * longint'(POLE_Q16), 16),
                     Y_MIN, Y_MAX);
        blk_x1[ch] = dly;
        blk_y1[ch] = y;
        w = clamp(x + rnd_shift(y * fb, 15), -32768, 32767);
        echo_mem[base + wp] = w[SAMPLE_W-1:0];
        wr_ptr[ch] = (wp + 1) % DELAY_DEPTH;
        o = clamp(rnd_shift(x * dry + dly * wet, 15), -32768, 32767);
        res.sample  = o[SAMPLE_W-1:0];
        res.channel = chb;
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] checker: %s", $time, what);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_mix_beat want;
        if (!i_rst_n) begin
            dlen_reg = DLEN_RESET;
            fb_reg   = FB_RESET;
            wet_reg  = WET_RESET;
            foreach (echo_mem[k])
                echo_mem[k] = '0;
            foreach (wr_ptr[c]) begin
                wr_ptr[c] = 0;
                blk_x1[c] = 0;
                blk_y1[c] = 0;
            end
            mix_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DELAY_LENGTH:  dlen_reg = i_cfg_wdata[DLEN_W-1:0];
                    CFG_FEEDBACK_GAIN: fb_reg   = i_cfg_wdata[FB_W-1:0];
                    CFG_WET_LEVEL:     wet_reg  = i_cfg_wdata[WET_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready)
                mix_expect_q = {mix_expect_q,
                                predict_mix(i_in_mon.sample_in, i_in_mon.channel)};
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (mix_expect_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected output beat: sample %0d ch %0d",
                                            $signed(i_out_mon.sample_out),
                                            i_out_mon.channel_out));
                end else begin
                    want = mix_expect_q.pop_front();
                    if (i_out_mon.sample_out !== want.sample)
                        flag_mismatch($sformatf("sample_out %0d, expected %0d (ch %0d)",
                                                $signed(i_out_mon.sample_out),
                                                $signed(want.sample), want.channel));
                    if (i_out_mon.channel_out !== want.channel)
                        flag_mismatch($sformatf("channel_out %0d, expected %0d",
                                                i_out_mon.channel_out, want.channel));
                end
            end
        end
        o_pending    <= mix_expect_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- sim/tb_feedback_echo_delay_core.sv -----
// top of the feedback echo delay core testbench: clock, reset, stimulus and verdict
// depends on fed_pkg, fed_in_if, fed_out_if, feedback_echo_delay_core and fed_checker
`timescale 1ns / 100ps

module tb_feedback_echo_delay_core;
    import fed_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    // the engine holds one sample at a time, so this tail is plenty
    localparam int DRAIN_CYCLES = 16;
    // roughly 800 samples, covered many times over by this limit
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 180;

    // index 3 decodes to nothing, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int cycle_cnt = 0;

    // idling knobs, percent of cycles
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // each bump asks the sink process for one long hold-off
    int hold_req_cnt   = 0;

    fed_in_if  in_bus ();
    fed_out_if out_bus ();

    feedback_echo_delay_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    fed_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // output side: random stalls, plus long hold-offs counted here on request
    initial begin : sink_proc
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != hold_req_cnt) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // offer one beat, with random idle cycles in front; returns at the handshake edge
    // with valid still high, so back-to-back beats follow without a gap in valid
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic ch);
        while ($urandom_range(99) < src_idle_pct) begin
            in_bus.valid <= 1'b0;
            in_bus.sample_in <= SAMPLE_W'($urandom);
            in_bus.channel <= 1'($urandom);
            @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= smp;
        in_bus.channel   <= ch;
        do
            @(posedge clk);
        while (!in_bus.ready);
    endtask

    // drop valid, wait for every expected beat, then let the pipeline settle
    task automatic wait_drain();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register writes only happen with the pipeline empty
    task automatic program_regs(input logic [CFG_DATA_W-1:0] dlen,
                                input logic [CFG_DATA_W-1:0] fbv,
                                input logic [CFG_DATA_W-1:0] wetv,
                                input bit                    poke_unused);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_DELAY_LENGTH;
        cfg_wdata <= dlen;
        @(posedge clk);
        cfg_idx   <= CFG_FEEDBACK_GAIN;
        cfg_wdata <= fbv;
        @(posedge clk);
        cfg_idx   <= CFG_WET_LEVEL;
        cfg_wdata <= wetv;
        @(posedge clk);
        if (poke_unused) begin
            cfg_idx   <= CFG_UNUSED_IDX;
            cfg_wdata <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // random samples, full scale mostly, with the rails and small values near zero now and then
    task automatic run_random(input int n_items, input int src_pct, input int sink_pct);
        logic [SAMPLE_W-1:0] smp;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int n = 0; n < n_items; n++) begin
            case ($urandom_range(7))
                0:       smp = 16'h7FFF;
                1:       smp = 16'h8000;
                2:       smp = SAMPLE_W'($urandom_range(64)) - 16'd32;
                default: smp = SAMPLE_W'($urandom);
            endcase
            push_sample(smp, 1'($urandom_range(1)));
        end
    endtask

    initial begin : stimulus
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_DELAY_LENGTH;
        cfg_wdata        <= '0;
        in_bus.valid     <= 1'b0;
        in_bus.sample_in <= '0;
        in_bus.channel   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: rails, zero and minus one across both channels, history reads as zero
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        wait_drain();

        // delay 0 behaves as 1, feedback and wet written above their maximum,
        // upper data bits set, plus a write to the unused index
        program_regs(17'd0, 17'h1FFFF, 17'h1FFFF, 1'b1);
        repeat (4) push_sample(16'h7FFF, 1'b0);
        repeat (3) push_sample(16'h8000, 1'b0);
        push_sample(16'h0001, 1'b1);
        push_sample(16'hFFFF, 1'b1);
        wait_drain();

        // longest delay reads untouched history, no feedback, dry only
        program_regs(17'd131071, 17'd0, 17'd0, 1'b0);
        push_sample(16'd12345, 1'b0);
        push_sample(-16'sd12345, 1'b1);
        push_sample(16'h7FFF, 1'b1);
        wait_drain();

        // one-sample delay, wet only, alternating bit patterns
        program_regs(17'd1, 17'h2AAA, 17'd32768, 1'b1);
        push_sample(16'h5555, 1'b0);
        push_sample(16'hAAAA, 1'b0);
        push_sample(16'd100, 1'b1);
        push_sample(16'hAAAA, 1'b1);
        wait_drain();

        // random phases; delays kept short so echoes and feedback build up
        program_regs(17'd3, 17'd32440, 17'd32768, 1'b0);
        run_random(PHASE_ITEMS, 0, 0);
        wait_drain();

        program_regs(17'd17, CFG_DATA_W'($urandom_range(32767)), 17'd0, 1'b1);
        run_random(PHASE_ITEMS, 50, 0);
        wait_drain();

        program_regs(CFG_DATA_W'($urandom_range(40, 1)), CFG_DATA_W'($urandom),
                     CFG_DATA_W'($urandom), 1'b0);
        run_random(PHASE_ITEMS, 0, 50);
        wait_drain();

        program_regs(17'd2, 17'd20000, CFG_DATA_W'($urandom_range(32768)), 1'b1);
        run_random(PHASE_ITEMS, 17, 17);
        wait_drain();

        // back-pressure: sink holds off for a long stretch while beats keep coming,
        // so the block fills and has to stall its input
        program_regs(17'd1, 17'd32000, 17'd24576, 1'b0);
        hold_req_cnt++;
        run_random(40, 0, 0);
        wait_drain();

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
